[rtl/core/crg_pkg.sv]
package crg_pkg;

    // Page store geometry
    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_BYTES = 4112;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int PB_W       = $clog2(PAGE_BYTES) + 1;
    localparam int PROD_W     = PAGE_W + PB_W;

    // Field widths
    localparam int SIZE_W    = 23;
    localparam int HI_W      = 64;
    localparam int MID_W     = 64;
    localparam int LO_W      = 32;
    localparam int DIG_W     = HI_W + MID_W + LO_W;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Front-to-back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Fragment count only needs to tell zero, one and more than one apart
    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [PAGE_W-1:0] LAST_IDX     = PAGE_W'(MAX_PAGES - 1);
    localparam logic [PB_W-1:0]   PAGE_BYTES_C = PB_W'(PAGE_BYTES);
    localparam logic [SIZE_W-1:0] SIZE_MAX     = '1;

    localparam logic KIND_FRAGMENT = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_BYTES,
        REG_ZERO_HI,
        REG_ZERO_MID,
        REG_ZERO_LO
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] block_bytes;
        logic [DIG_W-1:0]  zero_digest;   // {hi, mid, lo}
    } cfg_t;

    // Classified page, front to back
    typedef struct packed {
        logic              short_blk;
        logic              last_page;
        logic              changed;
        logic              is_zero;
        logic [PAGE_W-1:0] idx;
    } page_info_t;

    typedef struct packed {
        logic              kind;
        logic [PAGE_W-1:0] start_page;
        logic [SIZE_W-1:0] size_bytes;
        logic              holds_data;
        logic              full_store;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_TRIM,
        PH_SUM
    } phase_t;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [PROD_W-1:0] v);
        return (v > PROD_W'(SIZE_MAX)) ? SIZE_MAX : SIZE_W'(v);
    endfunction

endpackage

[rtl/core/crg_ram.sv]
module crg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/crg_front.sv]
module crg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [crg_pkg::DIG_W-1:0] in_digest,
    input  logic                in_full,
    input  logic                in_last,
    input  crg_pkg::cfg_t       cfg,
    output logic                q_valid,
    input  logic                q_ready,
    output crg_pkg::page_info_t q_data
);
    import crg_pkg::*;

    logic              accept;
    logic              push;
    logic              wr_en;
    logic              short_now;
    logic              zero_now;
    logic              byp_now;
    logic [DIG_W-1:0]  ram_rdata;
    logic [DIG_W-1:0]  old_digest;

    logic              a_valid_reg, a_valid_next;
    logic [PAGE_W-1:0] page_cnt_reg, page_cnt_next;
    logic              have_old_reg, have_old_next;

    // stage payload
    logic [PAGE_W-1:0] a_idx_reg;
    logic              a_short_reg;
    logic              a_last_reg;
    logic              a_zero_reg;
    logic              a_use_old_reg;
    logic [DIG_W-1:0]  a_digest_reg;
    logic              a_byp_reg;
    logic [DIG_W-1:0]  a_byp_data_reg;

    assign push     = a_valid_reg && q_ready;
    assign in_ready = !a_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;

    assign short_now = cfg.block_bytes < SIZE_W'(PAGE_BYTES);
    assign zero_now  = in_digest == cfg.zero_digest;
    assign wr_en     = push && !a_short_reg;
    // same page written this cycle: RAM read returns the stale entry
    assign byp_now   = wr_en && (a_idx_reg == page_cnt_reg);

    crg_ram #(
        .WIDTH (DIG_W),
        .DEPTH (MAX_PAGES)
    ) u_digest_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (a_idx_reg),
        .wdata (a_digest_reg),
        .re    (accept),
        .raddr (page_cnt_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        a_valid_next  = a_valid_reg;
        page_cnt_next = page_cnt_reg;
        have_old_next = have_old_reg;
        if (push)
        begin
            a_valid_next = 1'b0;
        end
        if (accept)
        begin
            a_valid_next = 1'b1;
            if (short_now)
            begin
                if (in_full)
                begin
                    have_old_next = 1'b0;
                end
            end
            else if (in_last)
            begin
                page_cnt_next = '0;
                have_old_next = 1'b1;
            end
            else if (page_cnt_reg != LAST_IDX)
            begin
                page_cnt_next = page_cnt_reg + PAGE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            page_cnt_reg <= '0;
            have_old_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= a_valid_next;
            page_cnt_reg <= page_cnt_next;
            have_old_reg <= have_old_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_idx_reg      <= page_cnt_reg;
            a_short_reg    <= short_now;
            a_last_reg     <= in_last;
            a_zero_reg     <= zero_now;
            a_use_old_reg  <= have_old_reg && !in_full;
            a_digest_reg   <= in_digest;
            a_byp_reg      <= byp_now;
            a_byp_data_reg <= a_digest_reg;
        end
    end

    assign old_digest = a_byp_reg ? a_byp_data_reg : ram_rdata;

    assign q_valid          = a_valid_reg;
    assign q_data.short_blk = a_short_reg;
    assign q_data.last_page = a_last_reg;
    assign q_data.changed   = !a_use_old_reg || (old_digest != a_digest_reg);
    assign q_data.is_zero   = a_zero_reg;
    assign q_data.idx       = a_idx_reg;

endmodule

[rtl/core/crg_queue.sv]
module crg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  crg_pkg::page_info_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output crg_pkg::page_info_t pop_data
);
    import crg_pkg::*;

    page_info_t        entries [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/crg_back.sv]
module crg_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [crg_pkg::SIZE_W-1:0] block_bytes,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  crg_pkg::page_info_t        q_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output crg_pkg::result_t           out_data
);
    import crg_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              run_active_reg, run_active_next;
    logic [PAGE_W-1:0] run_start_reg, run_start_next;
    logic              run_zero_reg, run_zero_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_full_reg, first_full_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    logic              slot_free;
    logic              mid_emit;
    logic              fs_now;
    logic [PROD_W-1:0] off;
    logic [SIZE_W-1:0] mid_size;
    logic [SIZE_W-1:0] trim_size;

    result_t           res_c;
    logic              need_slot;
    logic              pop;
    logic              frag;
    logic [SIZE_W-1:0] frag_sz;
    logic              clear_pass;
    logic              take_run;
    logic              step;

    assign slot_free = !out_valid_reg || out_ready;

    // A running fragment closes on an unchanged page or on a kind switch
    assign mid_emit = !q_data.short_blk && run_active_reg &&
                      (!q_data.changed || (q_data.is_zero != run_zero_reg));
    assign fs_now   = (cnt_reg == CNT_W'(1)) && first_full_reg;

    assign mid_size  = sat_size(PROD_W'(q_data.idx - run_start_reg) * PROD_W'(PAGE_BYTES_C));
    assign off       = PROD_W'(run_start_reg) * PROD_W'(PAGE_BYTES_C);
    assign trim_size = (PROD_W'(block_bytes) > off) ?
                       sat_size(PROD_W'(block_bytes) - off) : '0;

    // action decode
    always_comb
    begin
        res_c      = '0;
        need_slot  = 1'b0;
        pop        = 1'b0;
        frag       = 1'b0;
        frag_sz    = '0;
        clear_pass = 1'b0;
        take_run   = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (q_data.short_blk)
                begin
                    if (q_data.last_page)
                    begin
                        need_slot        = 1'b1;
                        res_c.kind       = KIND_SUMMARY;
                        res_c.full_store = 1'b1;
                        res_c.last       = 1'b1;
                    end
                    pop = 1'b1;
                end
                else
                begin
                    take_run = 1'b1;
                    if (mid_emit)
                    begin
                        need_slot        = 1'b1;
                        frag             = 1'b1;
                        frag_sz          = mid_size;
                        res_c.kind       = KIND_FRAGMENT;
                        res_c.start_page = run_start_reg;
                        res_c.size_bytes = mid_size;
                        res_c.holds_data = !run_zero_reg;
                        res_c.last       = !q_data.last_page;
                    end
                    pop = !q_data.last_page;
                end
            end
            PH_TRIM:
            begin
                need_slot = 1'b1;
                if (run_active_reg)
                begin
                    frag             = 1'b1;
                    frag_sz          = trim_size;
                    res_c.kind       = KIND_FRAGMENT;
                    res_c.start_page = run_start_reg;
                    res_c.size_bytes = trim_size;
                    res_c.holds_data = !run_zero_reg;
                end
                else
                begin
                    res_c.kind       = KIND_SUMMARY;
                    res_c.full_store = fs_now;
                    res_c.last       = 1'b1;
                    pop              = 1'b1;
                    clear_pass       = 1'b1;
                end
            end
            PH_SUM:
            begin
                need_slot        = 1'b1;
                res_c.kind       = KIND_SUMMARY;
                res_c.full_store = fs_now;
                res_c.last       = 1'b1;
                pop              = 1'b1;
                clear_pass       = 1'b1;
            end
            default:
            begin
            end
        endcase
        step = q_valid && (!need_slot || slot_free);
    end

    assign q_ready = pop && step;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (!q_data.short_blk && q_data.last_page)
                    begin
                        phase_next = PH_TRIM;
                    end
                end
                PH_TRIM:
                begin
                    phase_next = run_active_reg ? PH_SUM : PH_FIRST;
                end
                PH_SUM:
                begin
                    phase_next = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // run and pass state
    always_comb
    begin
        run_active_next = run_active_reg;
        run_start_next  = run_start_reg;
        run_zero_next   = run_zero_reg;
        cnt_next        = cnt_reg;
        first_full_next = first_full_reg;
        out_valid_next  = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            if (need_slot)
            begin
                out_valid_next = 1'b1;
            end
            if (take_run)
            begin
                run_active_next = q_data.changed;
                if (q_data.changed && (!run_active_reg || (q_data.is_zero != run_zero_reg)))
                begin
                    run_start_next = q_data.idx;
                    run_zero_next  = q_data.is_zero;
                end
            end
            if (frag)
            begin
                if (cnt_reg == '0)
                begin
                    first_full_next = frag_sz == block_bytes;
                end
                if (cnt_reg != CNT_MAX)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            if (clear_pass)
            begin
                run_active_next = 1'b0;
                run_start_next  = '0;
                run_zero_next   = 1'b0;
                cnt_next        = '0;
                first_full_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            run_active_reg <= 1'b0;
            run_start_reg  <= '0;
            run_zero_reg   <= 1'b0;
            cnt_reg        <= '0;
            first_full_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            run_active_reg <= run_active_next;
            run_start_reg  <= run_start_next;
            run_zero_reg   <= run_zero_next;
            cnt_reg        <= cnt_next;
            first_full_reg <= first_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && need_slot)
        begin
            out_data_reg <= res_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/changed_page_run_grouper.sv]
// Changed-page run grouper.
// Input stream: one request per page, in page order, carrying the page's 160-bit
// digest; tlast marks the final page of a checkpoint pass, tuser asks for a full
// pass (every page counts as changed). Output stream: fragment records (start
// page, byte size, zero/data kind) and one end-of-pass summary per pass, tuser
// telling the two apart; tlast marks the final result caused by an input page.
// Configuration: write block length and the all-zero page digest while idle.
// Throughput: one page per cycle while each page yields at most one result and
// the receiver keeps up; a page causing up to three results (closing fragment,
// trimmed final fragment, summary) holds the back end until the output port has
// moved them, one per cycle, and a pass end takes an extra back-end step when no
// fragment closes. A page passes the digest RAM read, compare and queue, and the
// output register. The 1024 x 160 digest RAM is read at accept and written as the
// page enters the queue, with a bypass for back-to-back hits.
// Reset clears the run state and the "old digests present" flag; the digest RAM
// is not cleared, its entries only count after a complete pass wrote them.
// A stalled receiver fills the output register, then the 4-entry queue, then the
// compare stage, after which s_axis_tready drops; nothing is lost.
module changed_page_run_grouper (
    input  logic         clk,
    input  logic         rst_n,
    // config write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // page digests in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,   // digest_hi[63:0], digest_mid[127:64], digest_lo[159:128]
    input  logic         s_axis_tuser,   // full_pass
    input  logic         s_axis_tlast,   // last_page
    // results out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // start_page[9:0], size_bytes[32:10], holds_data[33],
                                         // full_store[34], zero pad [39:35]
    output logic         m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last
);
    import crg_pkg::*;

    localparam int OUT_TDATA_W = 40;

    logic [SIZE_W-1:0] block_bytes_reg;
    logic [HI_W-1:0]   zero_hi_reg;
    logic [MID_W-1:0]  zero_mid_reg;
    logic [LO_W-1:0]   zero_lo_reg;
    cfg_t              cfg;

    page_info_t        fq_data;
    logic              fq_valid;
    logic              fq_ready;
    page_info_t        qb_data;
    logic              qb_valid;
    logic              qb_ready;
    result_t           res;

    // configuration registers, masked to width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= '0;
            zero_hi_reg     <= '0;
            zero_mid_reg    <= '0;
            zero_lo_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLOCK_BYTES: block_bytes_reg <= cfg_data[SIZE_W-1:0];
                REG_ZERO_HI:     zero_hi_reg     <= cfg_data[HI_W-1:0];
                REG_ZERO_MID:    zero_mid_reg    <= cfg_data[MID_W-1:0];
                REG_ZERO_LO:     zero_lo_reg     <= cfg_data[LO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.block_bytes = block_bytes_reg;
    assign cfg.zero_digest = {zero_hi_reg, zero_mid_reg, zero_lo_reg};

    // front: page index, digest RAM lookup, change and zero classification
    crg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_digest ({s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[159:128]}),
        .in_full   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .cfg       (cfg),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    crg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // back: run tracking, fragment records and pass summary
    crg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_bytes (block_bytes_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (res)
    );

    assign m_axis_tdata = OUT_TDATA_W'({res.full_store, res.holds_data,
                                        res.size_bytes, res.start_page});
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
